/* hw/rtl/ovl_pkg.sv */
`timescale 1ns / 1ps

package ovl_pkg;

    // Actions carried by each input word
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_FIND   = 2'd3
    } t_action;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    // Input word
    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  key;
        logic signed [VALUE_W-1:0]  new_value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] entry_count;
        logic               dropped;
    } t_out_word;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic               apply;
        t_action            action;
        logic [VALUE_W-1:0] key;
        logic [VALUE_W-1:0] new_value;
        logic [VALUE_W-1:0] cmp_key;
    } t_cell_cmd;

endpackage

/* hw/rtl/ovl_cell.sv */
`timescale 1ns / 1ps

module ovl_cell
    import ovl_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_cmd          i_cmd,
    input  logic               i_occupied,
    input  logic               i_tail,
    input  logic               i_seen_prev,
    input  logic [VALUE_W-1:0] i_next_entry,
    output logic [VALUE_W-1:0] o_entry,
    output logic               o_seen
);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               r_match;

    // Compare this entry against the incoming key on every edge
    always_ff @(posedge i_clk) begin
        r_match <= i_occupied && (r_entry == i_cmd.cmp_key);
    end

    // Pick the next entry: write tail, shift toward head, or replace
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.apply) begin
            case (i_cmd.action)
                ACT_APPEND: begin
                    if (i_tail) begin
                        n_entry = i_cmd.key;
                    end
                end
                ACT_DELETE: begin
                    if (i_seen_prev || r_match) begin
                        n_entry = i_next_entry;
                    end
                end
                ACT_UPDATE: begin
                    if (r_match && !i_seen_prev) begin
                        n_entry = i_cmd.new_value;
                    end
                end
                default: begin
                    n_entry = r_entry;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_seen  = i_seen_prev || r_match;

endmodule

/* hw/rtl/ordered_value_list_core.sv */
`timescale 1ns / 1ps

// Ordered value list: keeps up to CAPACITY signed 32-bit values in arrival
// order, one value per cell in a row of cells. On the accept edge every cell
// compares its value with the key; in the next cycle the first-match flag
// ripples down the row and the cells append, shift or replace. The result
// strobe o_done follows in the next cycle, in the same cycle that busy drops,
// so the next word can be accepted while o_done is high, but not while busy.
// The result is shown for exactly one cycle and must be captured then.
// Stored values have no reset; only the count, busy and done are cleared.

module ordered_value_list_core
    import ovl_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_data,
    output logic      o_done,
    output t_out_word o_result
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    t_action             r_action;
    logic [VALUE_W-1:0]  r_key;
    logic [VALUE_W-1:0]  r_new_value;
    t_out_word           r_result;
    t_out_word           n_result;
    t_cell_cmd           w_cmd;
    logic                w_accept;
    logic                w_hit;
    logic [31:0]         w_count_ext;
    logic [VALUE_W-1:0]  w_entry [CAPACITY];
    logic                w_seen  [CAPACITY+1];

    assign w_accept = start && !r_busy;

    // Broadcast command to the cells
    assign w_cmd.apply     = r_busy;
    assign w_cmd.action    = r_action;
    assign w_cmd.key       = r_key;
    assign w_cmd.new_value = r_new_value;
    assign w_cmd.cmp_key   = i_data.key;

    // Row of cells, first-match flag rippling from head to tail
    assign w_seen[0] = 1'b0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [VALUE_W-1:0] w_next;
        if (gi == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[gi];
        end else begin : g_mid
            assign w_next = w_entry[gi+1];
        end
        ovl_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_occupied   (CW'(gi) < r_count),
            .i_tail       (CW'(gi) == r_count),
            .i_seen_prev  (w_seen[gi]),
            .i_next_entry (w_next),
            .o_entry      (w_entry[gi]),
            .o_seen       (w_seen[gi+1])
        );
    end

    assign w_hit = w_seen[CAPACITY];

    // Work out the new count and the result word
    always_comb begin
        n_count  = r_count;
        n_result = '0;
        unique case (r_action)
            ACT_APPEND: begin
                if (r_count == CW'(CAPACITY)) begin
                    n_result.dropped = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_DELETE: begin
                n_result.hit = w_hit;
                if (w_hit) begin
                    n_count = r_count - CW'(1);
                end
            end
            ACT_UPDATE: begin
                n_result.hit = w_hit;
            end
            ACT_FIND: begin
                n_result.hit = w_hit;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        w_count_ext          = 32'(n_count);
        n_result.entry_count = w_count_ext[COUNT_W-1:0];
    end

    // Control: accept, apply, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= r_busy;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end
        end
    end

    // Hold the word under work and the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action    <= i_data.action;
            r_key       <= i_data.key;
            r_new_value <= i_data.new_value;
        end
        if (r_busy) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && !r_done)
        else $error("accepted word did not start work");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_done && !r_busy)
        else $error("result strobe did not follow work cycle");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.dropped) |-> (r_count == CW'(CAPACITY) && !r_result.hit))
        else $error("drop reported on a list that is not full");

endmodule
